>>> sv/i2cs_pkg.sv
// Shared types, codes and sizes of the I2C master sensor sequencer.
package i2cs_pkg;

	// Message buffer sizing
	localparam int BUF_DEPTH = 16;
	localparam int ADDR_W    = $clog2(BUF_DEPTH);
	localparam int IDX_W     = $clog2(BUF_DEPTH + 1);
	localparam int MAX_MEAS  = 15;
	localparam int CNT_W     = 4;
	localparam int CMP_W     = (IDX_W > CNT_W) ? IDX_W : CNT_W;

	// Queue sizing (depth is a power of two so pointers wrap on their own)
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = 1;
	localparam int Q_CNT_W = 2;

	// Input action codes
	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_EVENT = 1'b1;

	// Bus status event codes
	localparam logic [3:0] EV_START        = 4'd0;
	localparam logic [3:0] EV_REP_START    = 4'd1;
	localparam logic [3:0] EV_W_SLA_ACK    = 4'd2;
	localparam logic [3:0] EV_W_SLA_NACK   = 4'd3;
	localparam logic [3:0] EV_W_DATA_ACK   = 4'd4;
	localparam logic [3:0] EV_W_DATA_NACK  = 4'd5;
	localparam logic [3:0] EV_R_SLA_ACK    = 4'd6;
	localparam logic [3:0] EV_R_SLA_NACK   = 4'd7;
	localparam logic [3:0] EV_R_DATA_ACK   = 4'd8;
	localparam logic [3:0] EV_R_DATA_NACK  = 4'd9;
	localparam logic [3:0] EV_ARB_LOST     = 4'd10;
	localparam logic [3:0] EV_NO_INFO      = 4'd11;
	localparam logic [3:0] EV_BUS_ERROR    = 4'd12;

	// Result kinds
	localparam logic [1:0] KIND_CMD    = 2'd0;
	localparam logic [1:0] KIND_MEAS   = 2'd1;
	localparam logic [1:0] KIND_REJECT = 2'd2;

	// Sensor tags
	localparam logic [2:0] SENS_NONE    = 3'd0;
	localparam logic [2:0] SENS_ACCEL   = 3'd1;
	localparam logic [2:0] SENS_GYRO    = 3'd2;
	localparam logic [2:0] SENS_COMPASS = 3'd3;
	localparam logic [2:0] SENS_CAMERA  = 3'd4;

	// Seven-bit device addresses and their error bits
	localparam logic [6:0] DEV_ACCEL   = 7'h53;
	localparam logic [6:0] DEV_GYRO    = 7'h68;
	localparam logic [6:0] DEV_COMPASS = 7'h1E;
	localparam logic [6:0] DEV_CAMERA  = 7'h58;
	localparam logic [3:0] ERR_ACCEL   = 4'h1;
	localparam logic [3:0] ERR_GYRO    = 4'h2;
	localparam logic [3:0] ERR_COMPASS = 4'h4;
	localparam logic [3:0] ERR_CAMERA  = 4'h8;

	// Configuration register indexes and reset values
	localparam logic [1:0] REG_ACCEL   = 2'd0;
	localparam logic [1:0] REG_GYRO    = 2'd1;
	localparam logic [1:0] REG_COMPASS = 2'd2;
	localparam logic [1:0] REG_CAMERA  = 2'd3;
	localparam logic [7:0] RST_ACCEL   = 8'd167;
	localparam logic [7:0] RST_GYRO    = 8'd209;
	localparam logic [7:0] RST_COMPASS = 8'd61;
	localparam logic [7:0] RST_CAMERA  = 8'd177;

	// Classified operations handed from front to back
	typedef enum logic [3:0] {
		OP_LOAD,
		OP_START,
		OP_SEND,
		OP_WDATA,
		OP_RSLA,
		OP_RDATA,
		OP_REND,
		OP_ERROR,
		OP_NONE
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data;
		logic       last;
	} op_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       start;
		logic       stop;
		logic       ack;
		logic       bv;
		logic [7:0] value;
		logic [2:0] sensor;
		logic       last_of_run;
		logic [3:0] errors;
		logic       adc;
		logic       done;
		logic       busy;
	} result_t;

	typedef struct packed {
		logic [7:0] accel;
		logic [7:0] gyro;
		logic [7:0] compass;
		logic [7:0] camera;
	} cfg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_RUN_RD,
		ST_RUN_WR
	} seq_state_t;

endpackage

>>> sv/i2cs_regs.sv
// APB-style configuration registers holding the sensor read addresses.
module i2cs_regs (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output i2cs_pkg::cfg_t     cfg
);

	i2cs_pkg::cfg_t cfg_q;
	logic           wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	// Write the addressed register on the access beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.accel   <= i2cs_pkg::RST_ACCEL;
			cfg_q.gyro    <= i2cs_pkg::RST_GYRO;
			cfg_q.compass <= i2cs_pkg::RST_COMPASS;
			cfg_q.camera  <= i2cs_pkg::RST_CAMERA;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				i2cs_pkg::REG_ACCEL:   cfg_q.accel   <= pwdata[7:0];
				i2cs_pkg::REG_GYRO:    cfg_q.gyro    <= pwdata[7:0];
				i2cs_pkg::REG_COMPASS: cfg_q.compass <= pwdata[7:0];
				i2cs_pkg::REG_CAMERA:  cfg_q.camera  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Return the addressed register
	always_comb begin
		prdata = '0;
		unique case (paddr[3:2])
			i2cs_pkg::REG_ACCEL:   prdata = {24'd0, cfg_q.accel};
			i2cs_pkg::REG_GYRO:    prdata = {24'd0, cfg_q.gyro};
			i2cs_pkg::REG_COMPASS: prdata = {24'd0, cfg_q.compass};
			i2cs_pkg::REG_CAMERA:  prdata = {24'd0, cfg_q.camera};
			default:               prdata = '0;
		endcase
	end

endmodule

>>> sv/i2cs_front.sv
// Front end: accepts input beats, classifies them and queues the operations.
module i2cs_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic                 action,
	input  logic [7:0]           byte_in,
	input  logic                 last,
	input  logic [3:0]           bus_event,
	output logic                 op_valid,
	output i2cs_pkg::op_item_t   op_item,
	input  logic                 op_pop
);

	i2cs_pkg::op_item_t                  fifo_q [i2cs_pkg::Q_DEPTH];
	logic [i2cs_pkg::Q_PTR_W-1:0]        wr_ptr_q;
	logic [i2cs_pkg::Q_PTR_W-1:0]        rd_ptr_q;
	logic [i2cs_pkg::Q_CNT_W-1:0]        cnt_q;
	i2cs_pkg::op_t                       op_c;
	logic                                push_ok;
	logic                                pop_ok;

	assign full     = (cnt_q == i2cs_pkg::Q_CNT_W'(i2cs_pkg::Q_DEPTH));
	assign op_valid = (cnt_q != '0);
	assign push_ok  = push && !full;
	assign pop_ok   = op_pop && op_valid;
	assign op_item  = fifo_q[rd_ptr_q];

	// Classify the incoming beat
	always_comb begin
		op_c = i2cs_pkg::OP_NONE;
		if (action == i2cs_pkg::ACT_LOAD) begin
			op_c = i2cs_pkg::OP_LOAD;
		end else begin
			unique case (bus_event) inside
				i2cs_pkg::EV_START:                            op_c = i2cs_pkg::OP_START;
				i2cs_pkg::EV_REP_START, i2cs_pkg::EV_W_SLA_ACK: op_c = i2cs_pkg::OP_SEND;
				i2cs_pkg::EV_W_DATA_ACK:                       op_c = i2cs_pkg::OP_WDATA;
				i2cs_pkg::EV_R_SLA_ACK:                        op_c = i2cs_pkg::OP_RSLA;
				i2cs_pkg::EV_R_DATA_ACK:                       op_c = i2cs_pkg::OP_RDATA;
				i2cs_pkg::EV_R_DATA_NACK:                      op_c = i2cs_pkg::OP_REND;
				i2cs_pkg::EV_W_SLA_NACK, i2cs_pkg::EV_W_DATA_NACK,
				i2cs_pkg::EV_R_SLA_NACK, i2cs_pkg::EV_ARB_LOST,
				i2cs_pkg::EV_NO_INFO, i2cs_pkg::EV_BUS_ERROR:  op_c = i2cs_pkg::OP_ERROR;
				default:                                       op_c = i2cs_pkg::OP_NONE;
			endcase
		end
	end

	// Store the classified beat
	always_ff @(posedge clk) begin
		if (push_ok) begin
			fifo_q[wr_ptr_q].op   <= op_c;
			fifo_q[wr_ptr_q].data <= byte_in;
			fifo_q[wr_ptr_q].last <= last;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push_ok) wr_ptr_q <= wr_ptr_q + i2cs_pkg::Q_PTR_W'(1);
			if (pop_ok)  rd_ptr_q <= rd_ptr_q + i2cs_pkg::Q_PTR_W'(1);
			if (push_ok && !pop_ok)      cnt_q <= cnt_q + i2cs_pkg::Q_CNT_W'(1);
			else if (pop_ok && !push_ok) cnt_q <= cnt_q - i2cs_pkg::Q_CNT_W'(1);
		end
	end

endmodule

>>> sv/i2cs_back.sv
// Back end: sequencer that executes queued operations against the message buffer.
module i2cs_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  i2cs_pkg::cfg_t       cfg,
	input  logic                 op_valid,
	input  i2cs_pkg::op_item_t   op_item,
	output logic                 op_pop,
	output logic                 res_push,
	output i2cs_pkg::result_t    res_item,
	input  logic                 res_full
);

	i2cs_pkg::seq_state_t              state_q, state_d;
	i2cs_pkg::op_item_t                op_q;
	logic [i2cs_pkg::IDX_W-1:0]        idx_q, idx_d, len_q, len_d, run_ptr_q, run_ptr_d;
	logic                              busy_q, busy_d;
	logic [3:0]                        err_q, err_d;
	logic [7:0]                        buf0_q, buf2_q, rdata_q;
	logic [7:0]                        mem_q [i2cs_pkg::BUF_DEPTH];
	logic                              mem_we;
	logic [i2cs_pkg::ADDR_W-1:0]       raddr;
	logic                              phase_q, phase_d;
	logic [i2cs_pkg::CNT_W-1:0]        left1_q, left1_d, left2_q, left2_d;
	logic [2:0]                        tag1_q, tag1_d;
	logic                              adc_q, adc_d, done_q, done_d;

	logic                              idx_lt;
	logic [i2cs_pkg::IDX_W-1:0]        idx_inc, hi;
	logic [7:0]                        cur_byte, b0, b2;
	logic                              is_read;
	logic [2:0]                        tag_c;
	logic [i2cs_pkg::IDX_W-1:0]        c1_raw, c2_raw;
	logic [i2cs_pkg::CNT_W-1:0]        c1, c2, room;
	logic [3:0]                        err_mask;
	logic                              go;

	// Index and buffer helpers
	always_comb begin
		idx_lt   = (idx_q < i2cs_pkg::IDX_W'(i2cs_pkg::BUF_DEPTH));
		idx_inc  = idx_lt ? (idx_q + i2cs_pkg::IDX_W'(1)) : idx_q;
		hi       = idx_lt ? idx_q : i2cs_pkg::IDX_W'(i2cs_pkg::BUF_DEPTH - 1);
		cur_byte = idx_lt ? rdata_q : 8'd0;
		is_read  = (cur_byte == cfg.accel) || (cur_byte == cfg.gyro) ||
		           (cur_byte == cfg.compass) || (cur_byte == cfg.camera);
		// Bytes 0 and 2 as they stand after this beat's store
		b0 = (idx_q == '0) ? op_q.data : buf0_q;
		b2 = (idx_q == i2cs_pkg::IDX_W'(2)) ? op_q.data : buf2_q;
	end

	// Measurement run lengths for a read end
	always_comb begin
		if (b2 == cfg.accel)        tag_c = i2cs_pkg::SENS_ACCEL;
		else if (b2 == cfg.gyro)    tag_c = i2cs_pkg::SENS_GYRO;
		else if (b2 == cfg.compass) tag_c = i2cs_pkg::SENS_COMPASS;
		else                        tag_c = i2cs_pkg::SENS_NONE;
		c1_raw = ((tag_c != i2cs_pkg::SENS_NONE) && (idx_q >= i2cs_pkg::IDX_W'(3))) ?
		         (hi - i2cs_pkg::IDX_W'(2)) : '0;
		c1 = (i2cs_pkg::CMP_W'(c1_raw) > i2cs_pkg::CMP_W'(i2cs_pkg::MAX_MEAS)) ?
		     i2cs_pkg::CNT_W'(i2cs_pkg::MAX_MEAS) : i2cs_pkg::CNT_W'(c1_raw);
		room = i2cs_pkg::CNT_W'(i2cs_pkg::MAX_MEAS) - c1;
		c2_raw = ((b0 == cfg.camera) && (idx_q != '0)) ? hi : '0;
		c2 = (i2cs_pkg::CMP_W'(c2_raw) > i2cs_pkg::CMP_W'(room)) ?
		     room : i2cs_pkg::CNT_W'(c2_raw);
	end

	// Device error bit from the first buffered byte
	always_comb begin
		if (buf0_q[7:1] == i2cs_pkg::DEV_ACCEL)        err_mask = i2cs_pkg::ERR_ACCEL;
		else if (buf0_q[7:1] == i2cs_pkg::DEV_GYRO)    err_mask = i2cs_pkg::ERR_GYRO;
		else if (buf0_q[7:1] == i2cs_pkg::DEV_COMPASS) err_mask = i2cs_pkg::ERR_COMPASS;
		else if (buf0_q[7:1] == i2cs_pkg::DEV_CAMERA)  err_mask = i2cs_pkg::ERR_CAMERA;
		else                                           err_mask = 4'h0;
	end

	// A silent load needs no room in the result queue
	assign go = res_full ? ((op_q.op == i2cs_pkg::OP_LOAD) && !busy_q && !op_q.last) : 1'b1;

	// Sequencer next state and outputs
	always_comb begin
		state_d   = state_q;
		idx_d     = idx_q;
		len_d     = len_q;
		busy_d    = busy_q;
		err_d     = err_q;
		run_ptr_d = run_ptr_q;
		phase_d   = phase_q;
		left1_d   = left1_q;
		left2_d   = left2_q;
		tag1_d    = tag1_q;
		adc_d     = adc_q;
		done_d    = done_q;
		op_pop    = 1'b0;
		res_push  = 1'b0;
		res_item  = '0;
		mem_we    = 1'b0;
		raddr     = idx_q[i2cs_pkg::ADDR_W-1:0];

		unique case (state_q)
			i2cs_pkg::ST_IDLE: begin
				// Take the next operation and read the buffer at the index
				if (op_valid) begin
					op_pop  = 1'b1;
					state_d = i2cs_pkg::ST_DECIDE;
				end
			end

			i2cs_pkg::ST_DECIDE: begin
				if (go) begin
					res_push           = 1'b1;
					res_item.kind      = i2cs_pkg::KIND_CMD;
					res_item.last_of_run = 1'b1;
					state_d            = i2cs_pkg::ST_IDLE;
					unique case (op_q.op)
						i2cs_pkg::OP_LOAD: begin
							if (busy_q) begin
								res_item.kind = i2cs_pkg::KIND_REJECT;
							end else begin
								mem_we = idx_lt;
								if (op_q.last) begin
									len_d          = idx_inc;
									idx_d          = '0;
									res_item.start = 1'b1;
								end else begin
									idx_d    = idx_inc;
									res_push = 1'b0;
								end
							end
						end
						i2cs_pkg::OP_START: begin
							busy_d         = 1'b1;
							idx_d          = i2cs_pkg::IDX_W'(1);
							res_item.ack   = 1'b1;
							res_item.bv    = 1'b1;
							res_item.value = buf0_q;
						end
						i2cs_pkg::OP_SEND: begin
							res_item.bv    = 1'b1;
							res_item.value = cur_byte;
							idx_d          = idx_inc;
						end
						i2cs_pkg::OP_WDATA: begin
							if (idx_q < len_q) begin
								if (is_read) begin
									res_item.start = 1'b1;
								end else begin
									res_item.bv    = 1'b1;
									res_item.value = cur_byte;
									idx_d          = idx_inc;
								end
							end else begin
								res_item.stop = 1'b1;
								busy_d        = 1'b0;
								idx_d         = '0;
							end
						end
						i2cs_pkg::OP_RSLA: begin
							res_item.ack = 1'b1;
						end
						i2cs_pkg::OP_RDATA: begin
							res_item.ack = ({1'b0, idx_q} + (i2cs_pkg::IDX_W + 1)'(2)) !=
							               {1'b0, len_q};
							mem_we       = idx_lt;
							idx_d        = idx_inc;
						end
						i2cs_pkg::OP_REND: begin
							mem_we        = idx_lt;
							res_item.stop = 1'b1;
							res_item.adc  = (b2 == cfg.compass);
							res_item.done = (b0 == cfg.camera);
							adc_d         = (b2 == cfg.compass);
							done_d        = (b0 == cfg.camera);
							busy_d        = 1'b0;
							idx_d         = '0;
							tag1_d        = tag_c;
							left1_d       = c1;
							left2_d       = c2;
							// Start the measurement runs if any byte follows
							if (c1 != '0) begin
								phase_d              = 1'b0;
								run_ptr_d            = i2cs_pkg::IDX_W'(3);
								res_item.last_of_run = 1'b0;
								state_d              = i2cs_pkg::ST_RUN_RD;
							end else if (c2 != '0) begin
								phase_d              = 1'b1;
								run_ptr_d            = i2cs_pkg::IDX_W'(1);
								res_item.last_of_run = 1'b0;
								state_d              = i2cs_pkg::ST_RUN_RD;
							end
						end
						i2cs_pkg::OP_ERROR: begin
							err_d = err_q | err_mask;
						end
						default: ;
					endcase
					res_item.errors = err_d;
					res_item.busy   = busy_d;
				end
			end

			i2cs_pkg::ST_RUN_RD: begin
				// Read the next measurement byte
				raddr   = run_ptr_q[i2cs_pkg::ADDR_W-1:0];
				state_d = i2cs_pkg::ST_RUN_WR;
			end

			i2cs_pkg::ST_RUN_WR: begin
				// Hold the read address so the byte stays put while it waits
				raddr           = run_ptr_q[i2cs_pkg::ADDR_W-1:0];
				res_item.kind   = i2cs_pkg::KIND_MEAS;
				res_item.bv     = 1'b1;
				res_item.value  = rdata_q;
				res_item.sensor = phase_q ? i2cs_pkg::SENS_CAMERA : tag1_q;
				res_item.errors = err_q;
				res_item.adc    = adc_q;
				res_item.done   = done_q;
				res_item.busy   = busy_q;
				res_item.last_of_run = phase_q ? (left2_q == i2cs_pkg::CNT_W'(1)) :
				                       ((left1_q == i2cs_pkg::CNT_W'(1)) && (left2_q == '0));
				if (!res_full) begin
					res_push = 1'b1;
					state_d  = i2cs_pkg::ST_RUN_RD;
					if (!phase_q) begin
						left1_d   = left1_q - i2cs_pkg::CNT_W'(1);
						run_ptr_d = run_ptr_q + i2cs_pkg::IDX_W'(1);
						if (left1_q == i2cs_pkg::CNT_W'(1)) begin
							if (left2_q != '0) begin
								phase_d   = 1'b1;
								run_ptr_d = i2cs_pkg::IDX_W'(1);
							end else begin
								state_d = i2cs_pkg::ST_IDLE;
							end
						end
					end else begin
						left2_d   = left2_q - i2cs_pkg::CNT_W'(1);
						run_ptr_d = run_ptr_q + i2cs_pkg::IDX_W'(1);
						if (left2_q == i2cs_pkg::CNT_W'(1)) state_d = i2cs_pkg::ST_IDLE;
					end
				end
			end

			default: state_d = i2cs_pkg::ST_IDLE;
		endcase
	end

	// Buffer memory, registered read, and shadows of bytes 0 and 2
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[idx_q[i2cs_pkg::ADDR_W-1:0]] <= op_q.data;
			if (idx_q == '0) buf0_q <= op_q.data;
			if (idx_q == i2cs_pkg::IDX_W'(2)) buf2_q <= op_q.data;
		end
		rdata_q <= mem_q[raddr];
	end

	// Hold the operation being worked on and the run tag
	always_ff @(posedge clk) begin
		if (op_pop) op_q <= op_item;
		tag1_q <= tag1_d;
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= i2cs_pkg::ST_IDLE;
			idx_q     <= '0;
			len_q     <= '0;
			busy_q    <= 1'b0;
			err_q     <= '0;
			run_ptr_q <= '0;
			phase_q   <= 1'b0;
			left1_q   <= '0;
			left2_q   <= '0;
			adc_q     <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			idx_q     <= idx_d;
			len_q     <= len_d;
			busy_q    <= busy_d;
			err_q     <= err_d;
			run_ptr_q <= run_ptr_d;
			phase_q   <= phase_d;
			left1_q   <= left1_d;
			left2_q   <= left2_d;
			adc_q     <= adc_d;
			done_q    <= done_d;
		end
	end

endmodule

>>> sv/i2cs_resq.sv
// Result queue between the sequencer and the result ports.
module i2cs_resq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 res_push,
	input  i2cs_pkg::result_t    res_item,
	output logic                 res_full,
	output logic                 empty,
	input  logic                 pop,
	output i2cs_pkg::result_t    out_item
);

	i2cs_pkg::result_t                   fifo_q [i2cs_pkg::Q_DEPTH];
	logic [i2cs_pkg::Q_PTR_W-1:0]        wr_ptr_q;
	logic [i2cs_pkg::Q_PTR_W-1:0]        rd_ptr_q;
	logic [i2cs_pkg::Q_CNT_W-1:0]        cnt_q;
	logic                                push_ok;
	logic                                pop_ok;

	assign res_full = (cnt_q == i2cs_pkg::Q_CNT_W'(i2cs_pkg::Q_DEPTH));
	assign empty    = (cnt_q == '0);
	assign push_ok  = res_push && !res_full;
	assign pop_ok   = pop && !empty;
	assign out_item = fifo_q[rd_ptr_q];

	// Store a result beat
	always_ff @(posedge clk) begin
		if (push_ok) fifo_q[wr_ptr_q] <= res_item;
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push_ok) wr_ptr_q <= wr_ptr_q + i2cs_pkg::Q_PTR_W'(1);
			if (pop_ok)  rd_ptr_q <= rd_ptr_q + i2cs_pkg::Q_PTR_W'(1);
			if (push_ok && !pop_ok)      cnt_q <= cnt_q + i2cs_pkg::Q_CNT_W'(1);
			else if (pop_ok && !push_ok) cnt_q <= cnt_q - i2cs_pkg::Q_CNT_W'(1);
		end
	end

endmodule

>>> sv/i2c_master_sensor_sequencer.sv
// Top level of the I2C master sensor sequencer.
// Interrupt-driven I2C master sequencer. Load message bytes with action 0; the byte marked
// last asks for a start. Each bus status event (action 1) then returns one bus command, and a
// final NACKed read also returns the stored measurement bytes tagged by sensor, ending with
// last_of_run set. Inputs are classified and held in a two-entry queue, so two beats are
// taken back to back; the sequencer then handles one item at a time (buffer read, then
// decision), and on a read end reads out each measurement byte in turn, bounded by the single
// read port of the message buffer. Results wait in a two-entry queue and are taken with pop.
// Sensor read addresses sit in four 8-bit registers at byte addresses 0, 4, 8 and 12.
module i2c_master_sensor_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input items
	input  logic        push,
	output logic        full,
	input  logic        action,
	input  logic [7:0]  byte_in,
	input  logic        last,
	input  logic [3:0]  bus_event,
	// result items
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  result_kind,
	output logic        issue_start,
	output logic        issue_stop,
	output logic        ack_next,
	output logic        byte_valid,
	output logic [7:0]  byte_value,
	output logic [2:0]  sensor,
	output logic        last_of_run,
	output logic [3:0]  error_flags,
	output logic        adc_trigger,
	output logic        series_done,
	output logic        busy_res
);

	i2cs_pkg::cfg_t     cfg;
	logic               op_valid;
	i2cs_pkg::op_item_t op_item;
	logic               op_pop;
	logic               res_push;
	i2cs_pkg::result_t  res_item;
	logic               res_full;
	i2cs_pkg::result_t  out_item;

	i2cs_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	i2cs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.action    (action),
		.byte_in   (byte_in),
		.last      (last),
		.bus_event (bus_event),
		.op_valid  (op_valid),
		.op_item   (op_item),
		.op_pop    (op_pop)
	);

	i2cs_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.op_valid (op_valid),
		.op_item  (op_item),
		.op_pop   (op_pop),
		.res_push (res_push),
		.res_item (res_item),
		.res_full (res_full)
	);

	i2cs_resq u_resq (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.res_item (res_item),
		.res_full (res_full),
		.empty    (empty),
		.pop      (pop),
		.out_item (out_item)
	);

	// Spread the oldest result over the result ports
	assign result_kind = out_item.kind;
	assign issue_start = out_item.start;
	assign issue_stop  = out_item.stop;
	assign ack_next    = out_item.ack;
	assign byte_valid  = out_item.bv;
	assign byte_value  = out_item.value;
	assign sensor      = out_item.sensor;
	assign last_of_run = out_item.last_of_run;
	assign error_flags = out_item.errors;
	assign adc_trigger = out_item.adc;
	assign series_done = out_item.done;
	assign busy_res    = out_item.busy;

endmodule
